// File: rtl/core/rsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  localparam int CodeW  = 8;
  localparam int CoordW = 8;
  localparam int CountW = 8;
  localparam int NibW   = 4;

  localparam logic [NibW-1:0] NIBBLE_MASK = 4'hf;

  // Operation of the shared cursor adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [CoordW-1:0]   a;
    logic [CoordW-1:0]   b;
  } alu_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic signed [CoordW-1:0] offset_x;
    logic signed [CoordW-1:0] offset_y;
    logic                     run_last;
    logic                     sprite_done;
    logic [CountW-1:0]        pair_count;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/rsd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rsd_in_if;
  import rsd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rsd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rsd_out_if;
  import rsd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] offset_x;
  logic signed [CoordW-1:0] offset_y;
  logic                     run_last;
  logic                     sprite_done;
  logic [CountW-1:0]        pair_count;

  modport source (output valid, output offset_x, output offset_y, output run_last,
                  output sprite_done, output pair_count, input ready);
  modport sink (input valid, input offset_x, input offset_y, input run_last,
                input sprite_done, input pair_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rsd_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module rsd_alu (
  input  rsd_pkg::alu_req_t               req,
  output logic [rsd_pkg::CoordW-1:0]      y
);
  import rsd_pkg::*;

  // One 8-bit adder serves skips, flybacks and the per-pixel step.
  always_comb begin
    case (req.op)
      ALU_ADD: y = req.a + req.b;
      ALU_SUB: y = req.a - req.b;
      default: y = req.a;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/rsd_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rsd_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [rsd_pkg::CodeW-1:0]       code_byte,
  output logic                            in_ready,
  input  logic                            out_free,
  output logic                            out_load,
  output rsd_pkg::res_t                   out_word,
  output rsd_pkg::alu_req_t               alu_req,
  input  logic [rsd_pkg::CoordW-1:0]      alu_y
);
  import rsd_pkg::*;

  seq_state_t        state, state_next;
  logic [CoordW-1:0] cursor_x, cursor_x_next;
  logic [CoordW-1:0] cursor_y, cursor_y_next;
  logic              in_flyback, in_flyback_next;
  logic [CountW-1:0] pairs_emitted, pairs_emitted_next;
  logic [NibW-1:0]   remaining, remaining_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cursor_x      <= '0;
      cursor_y      <= '0;
      in_flyback    <= 1'b0;
      pairs_emitted <= '0;
      remaining     <= '0;
    end else begin
      state         <= state_next;
      cursor_x      <= cursor_x_next;
      cursor_y      <= cursor_y_next;
      in_flyback    <= in_flyback_next;
      pairs_emitted <= pairs_emitted_next;
      remaining     <= remaining_next;
    end
  end

  always_comb begin
    state_next         = state;
    cursor_x_next      = cursor_x;
    cursor_y_next      = cursor_y;
    in_flyback_next    = in_flyback;
    pairs_emitted_next = pairs_emitted;
    remaining_next     = remaining;
    in_ready           = 1'b0;
    out_load           = 1'b0;
    out_word           = '0;
    alu_req.op         = ALU_ADD;
    alu_req.a          = cursor_x;
    alu_req.b          = CoordW'(1);

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // The adder applies the skip in row phase and the flyback in flyback phase.
        if (in_flyback) begin
          alu_req.op = ALU_SUB;
          alu_req.b  = code_byte;
        end else begin
          alu_req.op = ALU_ADD;
          alu_req.b  = CoordW'(code_byte[CodeW-1:NibW]);
        end
        if (in_valid) begin
          if (!in_flyback) begin
            if (code_byte == '0) begin
              in_flyback_next = 1'b1;
            end else begin
              cursor_x_next  = alu_y;
              remaining_next = code_byte[NibW-1:0] & NIBBLE_MASK;
              if ((code_byte[NibW-1:0] & NIBBLE_MASK) != '0) begin
                state_next = S_EMIT;
              end
            end
          end else begin
            if (code_byte != '0) begin
              cursor_x_next   = alu_y;
              cursor_y_next   = cursor_y + CoordW'(1);
              in_flyback_next = 1'b0;
            end else begin
              state_next = S_DONE;
            end
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_word.offset_x    = $signed(cursor_x);
          out_word.offset_y    = $signed(cursor_y);
          out_word.run_last    = (remaining == NibW'(1));
          cursor_x_next        = alu_y;
          pairs_emitted_next   = pairs_emitted + CountW'(1);
          remaining_next       = remaining - NibW'(1);
          if (remaining == NibW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_word.run_last    = 1'b1;
          out_word.sprite_done = 1'b1;
          out_word.pair_count  = pairs_emitted;
          cursor_x_next        = '0;
          cursor_y_next        = '0;
          in_flyback_next      = 1'b0;
          pairs_emitted_next   = '0;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/rle_sprite_pixel_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Run-length sprite decoder. Sprite code bytes arrive one word at a time on
// in_ch; pixel offsets leave one word at a time on out_ch. Both channels move a
// word on a clock edge where valid and ready are both high.
// A row byte with a nonzero high nibble skips the cursor; its low nibble gives
// the number of pixel words to emit, the last of which carries run_last. A zero
// byte enters flyback, where the next nonzero byte moves the cursor back and
// down one line, and a second zero byte ends the sprite with a done word that
// carries the pixel count.
// Timing: an input word is taken while the sequencer is idle. A draw byte then
// stays in the emit state until all of its pixel words are placed, and a zero
// byte in flyback hands the end-of-sprite word to a done state. The single
// shared cursor adder performs the skip, the flyback and each per-pixel step
// in turn. A result is written to an output register in the cycle after it
// is formed. While the receiver stalls that register holds its word; a
// sequencer with a further word to place waits, and in_ch.ready stays low
// until that word has gone into the register. A byte that yields no word is
// taken without waiting on the output register.
// A synchronous reset empties the output register and returns the cursor, the
// line, the phase and the pixel count to zero, ready for a new sprite.

module rle_sprite_pixel_decoder_top (
  input  logic       clk,
  input  logic       rst,
  rsd_in_if.sink     in_ch,
  rsd_out_if.source  out_ch
);
  import rsd_pkg::*;

  alu_req_t          alu_req;
  logic [CoordW-1:0] alu_y;
  logic              out_free;
  logic              out_load;
  res_t              out_word;
  logic              out_valid;
  res_t              out_data;

  rsd_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  rsd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .code_byte (in_ch.code_byte),
    .in_ready  (in_ch.ready),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_word  (out_word),
    .alu_req   (alu_req),
    .alu_y     (alu_y)
  );

  // The output register may be refilled in the cycle its word is taken.
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_word;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.offset_x    = out_data.offset_x;
  assign out_ch.offset_y    = out_data.offset_y;
  assign out_ch.run_last    = out_data.run_last;
  assign out_ch.sprite_done = out_data.sprite_done;
  assign out_ch.pair_count  = out_data.pair_count;

endmodule

`default_nettype wire

// File: verif/rle_sprite_pixel_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the sprite decoder, predicts the pixel words that
// each accepted code byte should produce and compares them in order.
module rle_sprite_pixel_checker (
  input  logic clk,
  input  logic rst,
  rsd_in_if    in_ch,
  rsd_out_if   out_ch,
  output int   fail_count,
  output int   expected_left
);
  import rsd_pkg::*;

  logic [CoordW-1:0] cur_x;
  logic [CoordW-1:0] cur_y;
  logic              flyback;
  logic [CountW-1:0] pixels_drawn;
  res_t              pixel_q[$];

  task automatic clear_cursor();
    cur_x        = '0;
    cur_y        = '0;
    flyback      = 1'b0;
    pixels_drawn = '0;
  endtask

  task automatic predict_pixels(input logic [CodeW-1:0] code);
    res_t word;
    int   draw;
    if (!flyback) begin
      if (code == '0) begin
        flyback = 1'b1;
      end else begin
        cur_x = cur_x + CoordW'(code[CodeW-1:NibW]);
        draw  = int'(code[NibW-1:0] & NIBBLE_MASK);
        for (int i = 0; i < draw; i++) begin
          word.offset_x    = cur_x;
          word.offset_y    = cur_y;
          word.run_last    = (i == draw - 1);
          word.sprite_done = 1'b0;
          word.pair_count  = '0;
          pixel_q.push_back(word);
          cur_x        = cur_x + CoordW'(1);
          pixels_drawn = pixels_drawn + CountW'(1);
        end
      end
    end else if (code != '0) begin
      cur_x   = cur_x - code;
      cur_y   = cur_y + CoordW'(1);
      flyback = 1'b0;
    end else begin
      word.offset_x    = '0;
      word.offset_y    = '0;
      word.run_last    = 1'b1;
      word.sprite_done = 1'b1;
      word.pair_count  = pixels_drawn;
      pixel_q.push_back(word);
      clear_cursor();
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      clear_cursor();
      pixel_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.offset_x    = out_ch.offset_x;
        got.offset_y    = out_ch.offset_y;
        got.run_last    = out_ch.run_last;
        got.sprite_done = out_ch.sprite_done;
        got.pair_count  = out_ch.pair_count;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected word: expected none,", $time,
                   " got x=%0d y=%0d last=%0b done=%0b count=%0d",
                   got.offset_x, got.offset_y, got.run_last, got.sprite_done,
                   got.pair_count);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            $display("%0t: word mismatch: expected x=%0d y=%0d last=%0b done=%0b count=%0d",
                     $time, want.offset_x, want.offset_y, want.run_last, want.sprite_done,
                     want.pair_count);
            $display("%0t:                got      x=%0d y=%0d last=%0b done=%0b count=%0d",
                     $time, got.offset_x, got.offset_y, got.run_last, got.sprite_done,
                     got.pair_count);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_pixels(in_ch.code_byte);
      end
    end
    expected_left = pixel_q.size();
  end

endmodule

// File: verif/rle_sprite_pixel_decoder_top_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the run-length sprite decoder. The checker beside
// the block does all of the prediction and comparison; this module only feeds
// code bytes, throttles the result channel and decides the outcome.
module rle_sprite_pixel_decoder_top_tb;
  import rsd_pkg::*;

  // The run is split into phases that differ in how often the two sides hold
  // back (steady also opens with a tall sprite), so gaps land on every stage.
  typedef enum int {
    MODE_STEADY,
    MODE_SEND_IDLE,
    MODE_RECV_STALL,
    MODE_BOTH
  } idle_mode_t;

  localparam int RandomItems  = 176;
  localparam int PhaseItems   = RandomItems / 4;
  localparam int TallRows     = 16;
  localparam int SettleCycles = 20;

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   codes_sent     = 0;
  int   fail_count;
  int   expected_left;

  rsd_in_if  in_ch ();
  rsd_out_if out_ch ();

  rle_sprite_pixel_decoder_top uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rle_sprite_pixel_checker pixel_chk (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver decides afresh on every edge whether it will take a word.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // A backstop in case the block hangs: well beyond the slowest honest run.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic set_mode(input idle_mode_t mode);
    case (mode)
      MODE_STEADY: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      MODE_SEND_IDLE: begin
        send_idle_pct  = 75;
        recv_stall_pct = 0;
      end
      MODE_RECV_STALL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 75;
      end
      default: begin
        send_idle_pct  = 18;
        recv_stall_pct = 18;
      end
    endcase
  endtask

  // Offers one code byte and returns at the edge where it is taken. Idle
  // cycles are drawn one at a time, so a gap can be of any length; valid is
  // only lowered when a gap is actually taken, never dropped and raised again
  // in the same step.
  task automatic send_code(input logic [CodeW-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_byte <= code;
    do @(posedge clk); while (!in_ch.ready);
    codes_sent++;
  endtask

  // Holds the sender back until every predicted word has come out. The
  // checker updates its count on the accepting edge, so reading it from the
  // following edge on can never see a stale zero.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  // A well-formed sprite: a few rows of draw bytes, each row closed by a zero
  // byte and followed by a flyback amount, the last row by a second zero.
  task automatic random_sprite();
    int rows;
    rows = $urandom_range(1, 4);
    for (int r = 0; r < rows; r++) begin
      repeat ($urandom_range(1, 4)) send_code(CodeW'($urandom_range(1, 255)));
      send_code('0);
      if (r == rows - 1) begin
        send_code('0);
      end else begin
        send_code(CodeW'($urandom_range(1, 255)));
      end
    end
  endtask

  // One very wide row, long enough for the pixel count to wrap past 255.
  task automatic wide_sprite();
    repeat ($urandom_range(19, 21)) begin
      send_code({NibW'($urandom_range(0, 15)), NibW'($urandom_range(14, 15))});
    end
    send_code('0);
    send_code('0);
  endtask

  // Many short rows back to back, with a single pixel every few rows so that
  // the line number can be seen as it climbs.
  task automatic tall_sprite();
    for (int r = 0; r < TallRows; r++) begin
      if (r % 4 == 0) begin
        send_code({NibW'($urandom_range(0, 15)), NibW'(1)});
      end
      send_code('0);
      send_code(CodeW'($urandom_range(1, 255)));
    end
    send_code('0);
    send_code('0);
  endtask

  initial begin
    logic [CodeW-1:0] opening_codes[];
    int start_count;

    opening_codes = '{
      8'h00, 8'h00,               // empty sprite: done word with a zero count
      8'h10, 8'h01,               // skip without draw, then a single pixel
      8'hF0, 8'h0F, 8'hFF,        // largest skip alone, largest draw, both
      8'h00, 8'hFF,               // flyback by the largest amount
      8'h81, 8'h80, 8'h08,
      8'h00, 8'h01,               // flyback by the smallest amount
      8'h7F, 8'h00, 8'h00         // end of sprite after several rows
    };

    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.code_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening with both sides running flat out.
    set_mode(MODE_STEADY);
    foreach (opening_codes[i]) send_code(opening_codes[i]);
    wait_drained();

    // Random phases. Most of the traffic is whole sprites with random
    // content; the rest is stray bytes that leave the sprite in an odd phase.
    for (int m = MODE_STEADY; m <= MODE_BOTH; m++) begin
      set_mode(idle_mode_t'(m));
      start_count = codes_sent;
      if (m == MODE_STEADY) begin
        tall_sprite();
      end
      while (codes_sent - start_count < PhaseItems) begin
        case ($urandom_range(11))
          0:       send_code(CodeW'($urandom_range(0, 255)));
          1:       wide_sprite();
          default: random_sprite();
        endcase
      end
      // The sender waits for every pending word before the next phase.
      wait_drained();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: rle_sprite_pixel_decoder_top.f
rtl/core/rsd_pkg.sv
rtl/core/rsd_in_if.sv
rtl/core/rsd_out_if.sv
rtl/core/rsd_alu.sv
rtl/core/rsd_seq.sv
rtl/core/rle_sprite_pixel_decoder_top.sv
verif/rle_sprite_pixel_checker.sv
verif/rle_sprite_pixel_decoder_top_tb.sv
